>>> rtl/lkvc_pkg.sv
// lkvc_pkg: payload types, entry layout and codes for the lru key-value cache
// no dependencies; used by lru_key_value_cache
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    // operation codes carried in the mode field
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_ACCESS = 1'b1;

    // read value returned on a miss
    localparam logic signed [31:0] MISS_VALUE = 32'shFFFFFFFF;

    // width of the capacity register
    localparam int CFG_W = 5;

    // capacity register value after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] item_key;
        logic signed [31:0] item_value;
    } in_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
    } out_t;

    // one stored entry: key, value and recency stamp
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] stamp;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/lkvc_ram.sv
// lkvc_ram: generic single-write, single-read ram with registered read data
// no dependencies; instanced by lru_key_value_cache for the entry store
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// lru_key_value_cache: fully associative key-value store, lru replacement (lkvc_pkg, lkvc_ram)
// an accepted item scans limit = min(fill, capacity) entries through the ram read port, one
// per cycle, then the finish step writes the entry (on an add or an access hit) and, on an
// access, loads the result; a new item is taken only after the return to idle;
// an access holds in finish while the previous result is not taken. reset clears fill count,
// stamp counter, capacity (to 16) and handshakes; the entry ram is not cleared
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire lkvc_pkg::in_t             in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output lkvc_pkg::out_t                 out_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [lkvc_pkg::CFG_W-1:0] cfg_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = $bits(lkvc_pkg::entry_t);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [lkvc_pkg::CFG_W-1:0] cap_cfg_reg;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [31:0]            stamp_reg, stamp_next;
    logic [CW-1:0]          limit_reg, limit_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   vld_reg;
    logic [AW-1:0]          cmp_idx_reg;
    logic                   mode_reg;
    logic [31:0]            key_reg;
    logic [31:0]            val_reg;
    logic                   match_reg, match_next;
    logic [AW-1:0]          match_idx_reg, match_idx_next;
    logic [31:0]            match_val_reg, match_val_next;
    logic [31:0]            min_stamp_reg, min_stamp_next;
    logic [AW-1:0]          min_idx_reg, min_idx_next;
    logic                   out_valid_reg;
    lkvc_pkg::out_t         out_data_reg;

    logic [CW-1:0]          cap_eff;
    logic                   in_fire;
    logic                   issue;
    logic                   can_go;
    logic                   ram_we;
    logic [AW-1:0]          slot;
    lkvc_pkg::entry_t       rd_entry;
    lkvc_pkg::entry_t       wr_entry;
    logic [EW-1:0]          ram_rdata;

    // handshakes
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // capacity limited to 1..MAX_ENTRIES
    always_comb
    begin
        if (cap_cfg_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (32'(cap_cfg_reg) > MAX_ENTRIES)
        begin
            cap_eff = CW'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = CW'(cap_cfg_reg);
        end
    end

    // entry store
    assign issue    = (state_reg == ST_SCAN) && (idx_reg < limit_reg);
    assign rd_entry = lkvc_pkg::entry_t'(ram_rdata);

    lkvc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (wr_entry),
        .re    (issue),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // write slot: matched entry, next free entry, or least recently used
    always_comb
    begin
        priority if (match_reg)
        begin
            slot = match_idx_reg;
        end
        else if (fill_reg < cap_eff)
        begin
            slot = fill_reg[AW-1:0];
        end
        else
        begin
            slot = min_idx_reg;
        end
    end

    // finish step waits for the output register only on an access
    assign can_go = (mode_reg == lkvc_pkg::MODE_ADD) || !out_valid_reg || out_ready;
    assign ram_we = (state_reg == ST_FINISH) && can_go
                    && ((mode_reg == lkvc_pkg::MODE_ADD) || match_reg);

    always_comb
    begin
        wr_entry.key   = key_reg;
        wr_entry.value = (mode_reg == lkvc_pkg::MODE_ADD) ? val_reg : match_val_reg;
        wr_entry.stamp = stamp_reg;
    end

    // sequencer and scan datapath
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        stamp_next     = stamp_reg;
        limit_next     = limit_reg;
        idx_next       = idx_reg;
        match_next     = match_reg;
        match_idx_next = match_idx_reg;
        match_val_next = match_val_reg;
        min_stamp_next = min_stamp_reg;
        min_idx_next   = min_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    limit_next = (fill_reg < cap_eff) ? fill_reg : cap_eff;
                    idx_next   = '0;
                    match_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (can_go)
                begin
                    state_next = ST_IDLE;
                    if (ram_we)
                    begin
                        stamp_next = stamp_reg + 32'd1;
                    end
                    if ((mode_reg == lkvc_pkg::MODE_ADD) && !match_reg
                        && (fill_reg < cap_eff))
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // compare the entry read in the previous cycle
        if (vld_reg)
        begin
            if (!match_reg && (rd_entry.key == key_reg))
            begin
                match_next     = 1'b1;
                match_idx_next = cmp_idx_reg;
                match_val_next = rd_entry.value;
            end
            if ((cmp_idx_reg == '0) || (rd_entry.stamp < min_stamp_reg))
            begin
                min_stamp_next = rd_entry.stamp;
                min_idx_next   = cmp_idx_reg;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_cfg_reg   <= lkvc_pkg::CFG_RESET;
            fill_reg      <= '0;
            stamp_reg     <= '0;
            vld_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            stamp_reg <= stamp_next;
            vld_reg   <= issue;
            if (cfg_valid && cfg_ready)
            begin
                cap_cfg_reg <= cfg_data;
            end
            if ((state_reg == ST_FINISH) && can_go
                && (mode_reg == lkvc_pkg::MODE_ACCESS))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        limit_reg     <= limit_next;
        idx_reg       <= idx_next;
        cmp_idx_reg   <= idx_reg[AW-1:0];
        match_reg     <= match_next;
        match_idx_reg <= match_idx_next;
        match_val_reg <= match_val_next;
        min_stamp_reg <= min_stamp_next;
        min_idx_reg   <= min_idx_next;
        if (in_fire)
        begin
            mode_reg <= in_data.mode;
            key_reg  <= in_data.item_key;
            val_reg  <= in_data.item_value;
        end
        if ((state_reg == ST_FINISH) && can_go && (mode_reg == lkvc_pkg::MODE_ACCESS))
        begin
            out_data_reg.hit        <= match_reg;
            out_data_reg.read_value <= match_reg ? match_val_reg : lkvc_pkg::MISS_VALUE;
        end
    end

`ifndef NO_ASSERTIONS
    // fill count never passes the store depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= MAX_ENTRIES)
        else $error("fill count beyond store depth");

    // each entry write takes exactly one stamp
    a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (stamp_reg == $past(stamp_reg) + 32'd1))
        else $error("stamp counter out of step with entry writes");

    // scan never reads past the active limit
    a_scan_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= limit_reg))
        else $error("scan index past limit");

    // a result is only produced by the finish step of an access
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH
                                  && $past(mode_reg) == lkvc_pkg::MODE_ACCESS))
        else $error("result without a finished access");
`endif

endmodule

`default_nettype wire
